// ===== rtl/core/attnp_pkg.sv =====
`default_nettype none
package attnp_pkg;

  // buffer geometry
  localparam int MAX_PDU = 256;
  localparam int BUF_AW  = $clog2(MAX_PDU);

  // MTU clamp limits
  localparam logic [8:0] MTU_MIN = 9'd23;
  localparam logic [8:0] MTU_MAX = 9'(MAX_PDU);

  // item kinds
  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_VAL = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  // tuple modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_PACKED = 2'd1;
  localparam logic [1:0] MODE_DIRECT = 2'd2;

  // ATT opcodes
  localparam logic [7:0] OP_NTF   = 8'h1B;
  localparam logic [7:0] OP_MULTI = 8'h23;

  // configuration register indexes
  localparam logic CFG_MTU   = 1'b0;
  localparam logic CFG_MULTI = 1'b1;

  // one PDU byte on its way to the word packer
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  // one finished result word
  typedef struct packed {
    logic [63:0] pdu_word;
    logic [3:0]  valid_bytes;
    logic        pdu_end;
  } out_word_t;

endpackage
`default_nettype wire

// ===== rtl/core/attnp_front.sv =====
`default_nettype none
module attnp_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_push,
  output logic                        in_full,
  input  wire logic [1:0]             in_kind,
  input  wire logic [15:0]            in_handle,
  input  wire logic [9:0]             in_length,
  input  wire logic [7:0]             in_value_byte,
  input  wire logic [8:0]             mtu,
  input  wire logic                   multi_enabled,
  output logic                        bq_push,
  output attnp_pkg::byte_beat_t       bq_beat,
  input  wire logic                   bq_full
);
  import attnp_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FINISH  = 4'd1;
  localparam logic [3:0] S_DECIDE  = 4'd2;
  localparam logic [3:0] S_FLUSH   = 4'd3;
  localparam logic [3:0] S_FL_RD   = 4'd4;
  localparam logic [3:0] S_FL_PUSH = 4'd5;
  localparam logic [3:0] S_HDR_D   = 4'd6;
  localparam logic [3:0] S_HDR_P   = 4'd7;
  localparam logic [3:0] S_VALUE   = 4'd8;

  logic [3:0]  state_r, state_nxt;
  logic [3:0]  ret_r, ret_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] handle_r, handle_nxt;
  logic [9:0]  len_r, len_nxt;
  logic [7:0]  vb_r, vb_nxt;
  logic [8:0]  fill_r, fill_nxt;
  logic [6:0]  tuples_r, tuples_nxt;
  logic [9:0]  left_r, left_nxt;
  logic [8:0]  kept_r, kept_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [8:0]  idx_r, idx_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  logic [7:0]  mem [MAX_PDU];
  logic [7:0]  rd_data_r;
  logic        mem_we, mem_re;
  logic [BUF_AW-1:0] mem_waddr;
  logic [7:0]  mem_wdata;

  logic [8:0]  m_eff;
  logic [8:0]  m_room;
  logic        single;
  logic        fl_last;
  logic [8:0]  hdr_addr;

  // effective MTU
  always_comb begin
    if (mtu < MTU_MIN) m_eff = MTU_MIN;
    else if (mtu > MTU_MAX) m_eff = MTU_MAX;
    else m_eff = mtu;
  end
  assign m_room = m_eff - 9'd3;

  // flush read sequence: single tuple skips the length field
  assign single  = (tuples_r == 7'd1);
  assign fl_last = single ? ((idx_r == 9'd2 && fill_r <= 9'd5) ||
                             (idx_r > 9'd2 && idx_r == fill_r - 9'd1))
                          : (idx_r == fill_r - 9'd1);
  assign hdr_addr = fill_r + {7'd0, cnt_r};

  assign in_full = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    kind_nxt   = kind_r;
    handle_nxt = handle_r;
    len_nxt    = len_r;
    vb_nxt     = vb_r;
    fill_nxt   = fill_r;
    tuples_nxt = tuples_r;
    left_nxt   = left_r;
    kept_nxt   = kept_r;
    mode_nxt   = mode_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    bq_push    = 1'b0;
    bq_beat    = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = fill_r[BUF_AW-1:0];
    mem_wdata  = 8'd0;
    case (state_r)
      S_IDLE: begin
        if (in_push) begin
          kind_nxt   = in_kind;
          handle_nxt = in_handle;
          len_nxt    = in_length;
          vb_nxt     = in_value_byte;
          if (in_kind == KIND_HDR || in_kind == KIND_END) state_nxt = S_FINISH;
          else if (in_kind == KIND_VAL) state_nxt = S_VALUE;
        end
      end
      // zero-fill any bytes still owed by the open tuple
      S_FINISH: begin
        if (left_r == 10'd0) begin
          mode_nxt = MODE_IDLE;
          if (kind_r == KIND_END) begin
            ret_nxt   = S_IDLE;
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_DECIDE;
          end
        end else if (mode_r == MODE_PACKED) begin
          mem_we   = 1'b1;
          fill_nxt = fill_r + 9'd1;
          left_nxt = left_r - 10'd1;
        end else if (mode_r == MODE_DIRECT && kept_r != 9'd0) begin
          if (!bq_full) begin
            bq_push       = 1'b1;
            bq_beat.last  = (kept_r == 9'd1);
            kept_nxt      = kept_r - 9'd1;
            left_nxt      = left_r - 10'd1;
          end
        end else begin
          left_nxt = 10'd0;
        end
      end
      // pick plain or packed for the new tuple
      S_DECIDE: begin
        cnt_nxt  = 2'd0;
        left_nxt = len_r;
        if (!multi_enabled || ({1'b0, len_r} + 11'd5) > {2'b0, m_eff}) begin
          kept_nxt  = ({1'b0, len_r} < {2'b0, m_room}) ? len_r[8:0] : m_room;
          mode_nxt  = (len_r != 10'd0) ? MODE_DIRECT : MODE_IDLE;
          ret_nxt   = S_HDR_D;
          state_nxt = S_FLUSH;
        end else begin
          kept_nxt = 9'd0;
          mode_nxt = (len_r != 10'd0) ? MODE_PACKED : MODE_IDLE;
          ret_nxt  = S_HDR_P;
          if (({2'b0, fill_r} + 11'd4 + {1'b0, len_r}) > {2'b0, m_eff})
            state_nxt = S_FLUSH;
          else
            state_nxt = S_HDR_P;
        end
      end
      S_FLUSH: begin
        if (tuples_r == 7'd0) begin
          fill_nxt  = 9'd1;
          state_nxt = ret_r;
        end else if (!bq_full) begin
          bq_push      = 1'b1;
          bq_beat.data = single ? OP_NTF : OP_MULTI;
          idx_nxt      = 9'd1;
          state_nxt    = S_FL_RD;
        end
      end
      S_FL_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_FL_PUSH;
      end
      S_FL_PUSH: begin
        if (!bq_full) begin
          bq_push      = 1'b1;
          bq_beat.data = rd_data_r;
          bq_beat.last = fl_last;
          if (fl_last) begin
            fill_nxt   = 9'd1;
            tuples_nxt = 7'd0;
            state_nxt  = ret_r;
          end else begin
            idx_nxt   = (single && idx_r == 9'd2) ? 9'd5 : idx_r + 9'd1;
            state_nxt = S_FL_RD;
          end
        end
      end
      // plain notification head: opcode, handle
      S_HDR_D: begin
        if (!bq_full) begin
          bq_push = 1'b1;
          case (cnt_r)
            2'd0:    bq_beat.data = OP_NTF;
            2'd1:    bq_beat.data = handle_r[7:0];
            default: bq_beat.data = handle_r[15:8];
          endcase
          bq_beat.last = (cnt_r == 2'd2) && (kept_r == 9'd0);
          cnt_nxt      = cnt_r + 2'd1;
          if (cnt_r == 2'd2) state_nxt = S_IDLE;
        end
      end
      // packed tuple head: handle, length
      S_HDR_P: begin
        mem_we    = 1'b1;
        mem_waddr = hdr_addr[BUF_AW-1:0];
        case (cnt_r)
          2'd0:    mem_wdata = handle_r[7:0];
          2'd1:    mem_wdata = handle_r[15:8];
          2'd2:    mem_wdata = len_r[7:0];
          default: mem_wdata = {6'd0, len_r[9:8]};
        endcase
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          fill_nxt   = fill_r + 9'd4;
          tuples_nxt = tuples_r + 7'd1;
          state_nxt  = S_IDLE;
        end
      end
      S_VALUE: begin
        if (left_r == 10'd0) begin
          state_nxt = S_IDLE;
        end else if (mode_r == MODE_PACKED) begin
          mem_we    = 1'b1;
          mem_wdata = vb_r;
          fill_nxt  = fill_r + 9'd1;
          left_nxt  = left_r - 10'd1;
          if (left_r == 10'd1) mode_nxt = MODE_IDLE;
          state_nxt = S_IDLE;
        end else if (mode_r == MODE_DIRECT && kept_r != 9'd0) begin
          if (!bq_full) begin
            bq_push      = 1'b1;
            bq_beat.data = vb_r;
            bq_beat.last = (kept_r == 9'd1);
            kept_nxt     = kept_r - 9'd1;
            left_nxt     = left_r - 10'd1;
            if (left_r == 10'd1) mode_nxt = MODE_IDLE;
            state_nxt    = S_IDLE;
          end
        end else begin
          left_nxt = left_r - 10'd1;
          if (left_r == 10'd1) mode_nxt = MODE_IDLE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      fill_r   <= 9'd1;
      tuples_r <= 7'd0;
      left_r   <= 10'd0;
      kept_r   <= 9'd0;
      mode_r   <= MODE_IDLE;
      idx_r    <= 9'd0;
      cnt_r    <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      fill_r   <= fill_nxt;
      tuples_r <= tuples_nxt;
      left_r   <= left_nxt;
      kept_r   <= kept_nxt;
      mode_r   <= mode_nxt;
      idx_r    <= idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // latched item
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    handle_r <= handle_nxt;
    len_r    <= len_nxt;
    vb_r     <= vb_nxt;
  end

  // PDU buffer
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[idx_r[BUF_AW-1:0]];
  end

endmodule
`default_nettype wire

// ===== rtl/core/attnp_byte_q.sv =====
`default_nettype none
module attnp_byte_q (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire attnp_pkg::byte_beat_t  push_beat,
  output logic                        full,
  input  wire logic                   pop,
  output attnp_pkg::byte_beat_t       head_beat,
  output logic                        empty
);
  import attnp_pkg::*;

  byte_beat_t  slot_r [4];
  logic [1:0]  wr_r, wr_nxt;
  logic [1:0]  rd_r, rd_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign full      = (cnt_r == 3'd4);
  assign empty     = (cnt_r == 3'd0);
  assign head_beat = slot_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  // pointer update
  always_comb begin
    wr_nxt  = do_push ? wr_r + 2'd1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 2'd1 : rd_r;
    cnt_nxt = cnt_r + {2'd0, do_push} - {2'd0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_r] <= push_beat;
  end

endmodule
`default_nettype wire

// ===== rtl/core/attnp_back.sv =====
`default_nettype none
module attnp_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   bq_empty,
  input  wire attnp_pkg::byte_beat_t  bq_beat,
  output logic                        bq_pop,
  output logic                        out_empty,
  input  wire logic                   out_pop,
  output logic [63:0]                 out_pdu_word,
  output logic [3:0]                  out_valid_bytes,
  output logic                        out_pdu_end
);
  import attnp_pkg::*;

  logic [63:0] stg_r, stg_nxt;
  logic [2:0]  nb_r, nb_nxt;
  out_word_t   ofifo_r [2];
  logic        owr_r, ord_r;
  logic [1:0]  ocnt_r;
  logic [63:0] merged;
  logic        emit;
  out_word_t   new_word;
  logic        do_opop;

  // take a byte only when a finished word would have a slot
  assign bq_pop   = !bq_empty && (ocnt_r != 2'd2);
  assign merged   = stg_r | ({56'd0, bq_beat.data} << {nb_r, 3'b000});
  assign emit     = bq_pop && (bq_beat.last || nb_r == 3'd7);
  assign do_opop  = out_pop && !out_empty;

  always_comb begin
    new_word.pdu_word    = merged;
    new_word.valid_bytes = {1'b0, nb_r} + 4'd1;
    new_word.pdu_end     = bq_beat.last;
    stg_nxt = stg_r;
    nb_nxt  = nb_r;
    if (emit) begin
      stg_nxt = 64'd0;
      nb_nxt  = 3'd0;
    end else if (bq_pop) begin
      stg_nxt = merged;
      nb_nxt  = nb_r + 3'd1;
    end
  end

  assign out_empty       = (ocnt_r == 2'd0);
  assign out_pdu_word    = ofifo_r[ord_r].pdu_word;
  assign out_valid_bytes = ofifo_r[ord_r].valid_bytes;
  assign out_pdu_end     = ofifo_r[ord_r].pdu_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r  <= 64'd0;
      nb_r   <= 3'd0;
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      stg_r  <= stg_nxt;
      nb_r   <= nb_nxt;
      if (emit) owr_r <= ~owr_r;
      if (do_opop) ord_r <= ~ord_r;
      ocnt_r <= ocnt_r + {1'b0, emit} - {1'b0, do_opop};
    end
  end

  // result word queue
  always_ff @(posedge clk) begin
    if (emit) ofifo_r[owr_r] <= new_word;
  end

endmodule
`default_nettype wire

// ===== rtl/core/ble_att_notification_packer.sv =====
// Packs (handle, length, value bytes) tuples into ATT notification PDUs and
// returns them as 8-byte little-endian words. One item is taken at a time;
// a packed head writes four buffer bytes and a plain head pushes three, a
// header that closes a tuple first zero-fills the bytes still owed, and a
// flush of a packed PDU reads the 256-byte buffer back byte by byte, each
// read followed by a push, and holds the input off all the while. The word
// packer and a two-word result queue run behind a four-byte queue, so a
// stalled consumer only stops the front once those fill.
`default_nettype none
module ble_att_notification_packer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_handle,
  input  wire logic [9:0]  in_length,
  input  wire logic [7:0]  in_value_byte,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [63:0]      out_pdu_word,
  output logic [3:0]       out_valid_bytes,
  output logic             out_pdu_end
);
  import attnp_pkg::*;

  logic [8:0]  mtu_r;
  logic        multi_r;
  logic        bq_push, bq_full, bq_pop, bq_empty;
  byte_beat_t  bq_in, bq_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtu_r   <= MTU_MIN;
      multi_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MTU) mtu_r <= cfg_data;
      if (cfg_index == CFG_MULTI) multi_r <= cfg_data[0];
    end
  end

  attnp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_kind       (in_kind),
    .in_handle     (in_handle),
    .in_length     (in_length),
    .in_value_byte (in_value_byte),
    .mtu           (mtu_r),
    .multi_enabled (multi_r),
    .bq_push       (bq_push),
    .bq_beat       (bq_in),
    .bq_full       (bq_full)
  );

  attnp_byte_q u_byte_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (bq_push),
    .push_beat (bq_in),
    .full      (bq_full),
    .pop       (bq_pop),
    .head_beat (bq_head),
    .empty     (bq_empty)
  );

  attnp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .bq_empty        (bq_empty),
    .bq_beat         (bq_head),
    .bq_pop          (bq_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pdu_word    (out_pdu_word),
    .out_valid_bytes (out_valid_bytes),
    .out_pdu_end     (out_pdu_end)
  );

  // an accepted item of a used kind always blocks the next beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full &&
    (in_kind == KIND_HDR || in_kind == KIND_VAL || in_kind == KIND_END) |=> in_full)
    else $error("input not held off after accept");

  // only the closing word of a PDU may be short
  a_full_words: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pdu_end |-> out_valid_bytes == 4'd8)
    else $error("short word inside a PDU");

  // a word carries one to eight bytes
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_valid_bytes != 4'd0 && out_valid_bytes <= 4'd8)
    else $error("bad byte count");

  // the packer never takes a byte the queue does not hold
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    bq_pop |-> !bq_empty)
    else $error("byte queue underflow");

endmodule
`default_nettype wire
